// ===== design/energy_silence_auto_mute_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the energy silence auto-mute block
// Clocked, reset-qualified property wrappers used by the gate core (esam_gate).
// ----------------------------------------------------------------------------
`ifndef ENERGY_SILENCE_AUTO_MUTE_ASSERT_SVH
`define ENERGY_SILENCE_AUTO_MUTE_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define ESAM_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("esam assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define ESAM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("esam assertion failed");

// Antecedent implies consequent in the same cycle.
`define ESAM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("esam assertion failed");

`endif

// ===== design/esam_pkg.sv =====
// ----------------------------------------------------------------------------
// esam_pkg
// Types, widths and register codes for the energy silence auto-mute block.
// ----------------------------------------------------------------------------
package esam_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SQ_W     = 31;  // |sample|^2 <= 2^30
  localparam int unsigned ENERGY_W = 38;
  localparam int unsigned COUNT_W  = 17;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned CFG_W    = 38;  // widest register
  localparam int unsigned CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       packet_end;
    logic                       rearm;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       gate_is_open;
    logic                       packet_last;
  } out_word_t;

  // word between the square stage and the gate core
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       packet_end;
    logic                       rearm;
    logic [SQ_W-1:0]            square;
  } sq_word_t;

endpackage

// ===== design/esam_square.sv =====
// ----------------------------------------------------------------------------
// esam_square
// Input register and squaring stage; passes each word on with its square.
// ----------------------------------------------------------------------------
module esam_square (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  esam_pkg::in_word_t  in_word_i,
  output logic                sq_valid_o,
  input  logic                sq_ready_i,
  output esam_pkg::sq_word_t  sq_word_o
);
  import esam_pkg::*;

  in_word_t          a_q;
  logic              a_valid_q;
  sq_word_t          b_q;
  logic              b_valid_q;
  logic              b_free;
  logic              a_move;
  logic signed [31:0] prod;

  assign b_free     = !b_valid_q || sq_ready_i;
  assign a_move     = a_valid_q && b_free;
  assign in_ready_o = !a_valid_q || b_free;

  assign prod = a_q.sample_in * a_q.sample_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        a_valid_q <= in_valid_i;
      end
      if (b_free) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_q <= in_word_i;
    end
    if (a_move) begin
      b_q.sample     <= a_q.sample_in;
      b_q.packet_end <= a_q.packet_end;
      b_q.rearm      <= a_q.rearm;
      b_q.square     <= prod[SQ_W-1:0];
    end
  end

  assign sq_valid_o = b_valid_q;
  assign sq_word_o  = b_q;

endmodule

// ===== design/esam_gate.sv =====
// ----------------------------------------------------------------------------
// esam_gate
// Energy accumulator, end-of-packet rule, configuration and output register.
// ----------------------------------------------------------------------------
`include "energy_silence_auto_mute_assert.svh"

module esam_gate (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [esam_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [esam_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                sq_valid_i,
  output logic                                sq_ready_o,
  input  esam_pkg::sq_word_t                  sq_word_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output esam_pkg::out_word_t                 out_word_o
);
  import esam_pkg::*;

  logic [ENERGY_W-1:0] thr_q;
  logic [LIMIT_W-1:0]  limit_q;

  logic [ENERGY_W-1:0] pe_q, pe_d;
  logic [ENERGY_W-1:0] peak_q, peak_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic                gate_q, gate_d;

  logic                out_valid_q;
  out_word_t           out_q;

  logic                take;
  logic [ENERGY_W-1:0] pe_base, peak_base;
  logic [COUNT_W-1:0]  cnt_base, cnt_inc;
  logic                open_now;
  logic [ENERGY_W:0]   sum;
  logic [ENERGY_W-1:0] energy;

  assign sq_ready_o = !out_valid_q || out_ready_i;
  assign take       = sq_valid_i && sq_ready_o;

  always_comb begin
    // rearm clears energy, peak and count and opens the gate before the word is handled
    pe_base   = sq_word_i.rearm ? '0 : pe_q;
    peak_base = sq_word_i.rearm ? '0 : peak_q;
    cnt_base  = sq_word_i.rearm ? '0 : cnt_q;
    open_now  = sq_word_i.rearm | gate_q;

    sum = {1'b0, pe_base} + (ENERGY_W+1)'(sq_word_i.square);
    if (!open_now) begin
      energy = pe_base;
    end else if (sum[ENERGY_W]) begin
      energy = {ENERGY_W{1'b1}};
    end else begin
      energy = sum[ENERGY_W-1:0];
    end

    cnt_inc = (cnt_base == {COUNT_W{1'b1}}) ? cnt_base : cnt_base + COUNT_W'(1);

    pe_d   = energy;
    peak_d = peak_base;
    cnt_d  = cnt_base;
    gate_d = open_now;

    if (sq_word_i.packet_end) begin
      pe_d = '0;
      if (open_now) begin
        priority if (energy > peak_base) begin
          peak_d = energy;
          cnt_d  = '0;
        end else if (energy < thr_q) begin
          cnt_d = cnt_inc;
          if (cnt_inc > {1'b0, limit_q}) begin
            gate_d = 1'b0;
            peak_d = '0;
          end
        end else begin
          cnt_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= '0;
      limit_q     <= '0;
      pe_q        <= '0;
      peak_q      <= '0;
      cnt_q       <= '0;
      gate_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_THRESHOLD: thr_q   <= cfg_data_i[ENERGY_W-1:0];
          CFG_LIMIT:     limit_q <= cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (take) begin
        pe_q   <= pe_d;
        peak_q <= peak_d;
        cnt_q  <= cnt_d;
        gate_q <= gate_d;
      end
      if (sq_ready_o) begin
        out_valid_q <= sq_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q.sample_out   <= open_now ? sq_word_i.sample : '0;
      out_q.gate_is_open <= open_now;
      out_q.packet_last  <= sq_word_i.packet_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `ESAM_ASSERT_IMP(a_closed_mutes, out_valid_o && !out_word_o.gate_is_open,
                   out_word_o.sample_out == '0)
  `ESAM_ASSERT_NEXT(a_pkt_end_clears, take && sq_word_i.packet_end, pe_q == '0)
  `ESAM_ASSERT_IMP(a_close_at_end, $fell(gate_q),
                   $past(take) && $past(sq_word_i.packet_end))
  `ESAM_ASSERT_IMP(a_closed_no_energy, !gate_q, pe_q == '0 && peak_q == '0)

endmodule

// ===== design/energy_silence_auto_mute.sv =====
// ----------------------------------------------------------------------------
// energy_silence_auto_mute
// Block-energy noise gate for a 16-bit audio stream.
// ----------------------------------------------------------------------------
// One word in per clock, one word out per word in, in order. Each accepted
// word passes through three registers on its way to the output: an input
// register, a register holding the sample's square (16x16 signed multiply),
// then the gate core where the saturating 38-bit energy accumulate and the
// end-of-packet compare against peak and threshold update the state and load
// the output register. That accumulate-and-decide loop is combinational
// between the gate core's state registers, which sets the sustained rate of
// one word per cycle while the output does not stall; back-pressure from the
// output stalls the whole pipe without losing or repeating words.
// Configuration writes (threshold at index 0, quiet-packet limit at index 1)
// take effect at the next edge and should only be issued while idle.
// ----------------------------------------------------------------------------
module energy_silence_auto_mute (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [esam_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [esam_pkg::CFG_W-1:0]      cfg_data_i,
  // input words
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  esam_pkg::in_word_t              in_word_i,
  // result words
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output esam_pkg::out_word_t             out_word_o
);
  import esam_pkg::*;

  // square stage to gate core
  logic     sq_valid;
  logic     sq_ready;
  sq_word_t sq_word;

  // input register and squarer
  esam_square u_square (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .sq_valid_o (sq_valid),
    .sq_ready_i (sq_ready),
    .sq_word_o  (sq_word)
  );

  // accumulator, packet rule, gate state and output register
  esam_gate u_gate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sq_valid_i  (sq_valid),
    .sq_ready_o  (sq_ready),
    .sq_word_i   (sq_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
